// File: rtl/sbra_pkg.sv
package sbra_pkg;

  // Storage geometry.
  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned BLK_LEN      = 32;
  localparam int unsigned BLK_CNT      = MAX_ELEMENTS / BLK_LEN;
  localparam int unsigned DATA_W       = 32;

  localparam int unsigned ELEM_AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned BLK_AW  = $clog2(BLK_CNT);
  localparam int unsigned OFF_W   = $clog2(BLK_LEN);
  localparam int unsigned CNT_W   = ELEM_AW + 1;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_AW  = 1;

  typedef logic [DATA_W-1:0] data_t;

  // Combine operator codes.
  localparam logic [MODE_W-1:0] MODE_SUM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;

  // Item operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] CFG_ELEMENT_COUNT = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_COMBINE_MODE  = 1'd1;

  typedef struct packed {
    logic [CNT_W-1:0]  element_count;
    logic [MODE_W-1:0] combine_mode;
  } cfg_t;

  // Element memory access request.
  typedef struct packed {
    logic               we;
    logic [ELEM_AW-1:0] waddr;
    data_t              wdata;
    logic [ELEM_AW-1:0] raddr;
  } elem_req_t;

  // Block aggregate memory access request.
  typedef struct packed {
    logic              we;
    logic [BLK_AW-1:0] waddr;
    data_t             wdata;
    logic [BLK_AW-1:0] raddr;
  } blk_req_t;

  // Neutral value of the selected operator.
  function automatic data_t identity_of(input logic [MODE_W-1:0] mode);
    data_t res;
    case (mode)
      MODE_MIN: res = {1'b0, {(DATA_W-1){1'b1}}};
      MODE_MAX: res = {1'b1, {(DATA_W-1){1'b0}}};
      default:  res = '0;
    endcase
    return res;
  endfunction

  // One step of the operator; the unused code acts as the sum.
  function automatic data_t combine_of(input logic [MODE_W-1:0] mode,
                                       input data_t a, input data_t b);
    data_t res;
    case (mode)
      MODE_MIN: res = ($signed(a) <= $signed(b)) ? a : b;
      MODE_MAX: res = ($signed(a) >= $signed(b)) ? a : b;
      default:  res = a + b;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/sbra_ram.sv
module sbra_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Synchronous write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Synchronous read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/sbra_ctrl.sv
module sbra_ctrl import sbra_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                operation_i,
  input  logic [ELEM_AW-1:0]  first_index_i,
  input  logic [ELEM_AW-1:0]  last_index_i,
  input  data_t               element_value_i,
  input  cfg_t                cfg_i,
  output elem_req_t           elem_req_o,
  input  data_t               elem_rdata_i,
  output blk_req_t            blk_req_o,
  input  data_t               blk_rdata_i,
  output logic                result_valid_o,
  output data_t               aggregate_o,
  output logic                in_range_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_LEFT  = 3'd3;
  localparam logic [2:0] ST_MID   = 3'd4;
  localparam logic [2:0] ST_RIGHT = 3'd5;
  localparam logic [2:0] ST_DRAIN = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [ELEM_AW-1:0] cur_q, cur_d;
  logic [ELEM_AW-1:0] stop_q, stop_d;
  logic [BLK_AW-1:0]  bcur_q, bcur_d;
  logic               rd_vld_q, rd_vld_d;
  logic               rd_blk_q, rd_blk_d;
  logic               res_vld_q, res_vld_d;
  logic               op_q, op_d;
  logic [ELEM_AW-1:0] lidx_q, lidx_d;
  logic [ELEM_AW-1:0] ridx_q, ridx_d;
  data_t              val_q, val_d;
  data_t              acc_q, acc_d;
  data_t              res_agg_q, res_agg_d;
  logic               res_rng_q, res_rng_d;

  logic [CNT_W-1:0]   live_n;
  logic [BLK_AW-1:0]  lb, rb;
  logic [ELEM_AW-1:0] blk_first;
  logic [CNT_W-1:0]   blk_end, blk_lim;
  logic [ELEM_AW-1:0] blk_stop;
  logic               write_ok, query_ok;
  data_t              rd_data, acc_next;

  // Live element count saturates at the capacity.
  assign live_n = (cfg_i.element_count > CNT_W'(MAX_ELEMENTS)) ?
                  CNT_W'(MAX_ELEMENTS) : cfg_i.element_count;

  assign lb = lidx_q[ELEM_AW-1 -: BLK_AW];
  assign rb = ridx_q[ELEM_AW-1 -: BLK_AW];

  // Last live element of the block that a write touches.
  assign blk_first = {lb, {OFF_W{1'b0}}};
  assign blk_end   = {1'b0, blk_first} + CNT_W'(BLK_LEN);
  assign blk_lim   = (blk_end > live_n) ? live_n : blk_end;
  assign blk_stop  = ELEM_AW'(blk_lim - CNT_W'(1));

  assign write_ok = {1'b0, lidx_q} < live_n;
  assign query_ok = ({1'b0, ridx_q} < live_n) && (lidx_q <= ridx_q);

  // Read data returns in the cycle after the address; fold it into the running value.
  assign rd_data  = rd_blk_q ? blk_rdata_i : elem_rdata_i;
  assign acc_next = rd_vld_q ? combine_of(cfg_i.combine_mode, acc_q, rd_data) : acc_q;

  // Sequencer: clearing pass, then one item at a time over the memories.
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    stop_d    = stop_q;
    bcur_d    = bcur_q;
    rd_vld_d  = 1'b0;
    rd_blk_d  = rd_blk_q;
    res_vld_d = 1'b0;
    op_d      = op_q;
    lidx_d    = lidx_q;
    ridx_d    = ridx_q;
    val_d     = val_q;
    acc_d     = acc_next;
    res_agg_d = res_agg_q;
    res_rng_d = res_rng_q;

    elem_req_o.we    = 1'b0;
    elem_req_o.waddr = cur_q;
    elem_req_o.wdata = '0;
    elem_req_o.raddr = cur_q;
    blk_req_o.we     = 1'b0;
    blk_req_o.waddr  = lb;
    blk_req_o.wdata  = acc_next;
    blk_req_o.raddr  = bcur_q;

    case (state_q)
      ST_CLEAR: begin
        elem_req_o.we   = 1'b1;
        blk_req_o.we    = {1'b0, cur_q} < CNT_W'(BLK_CNT);
        blk_req_o.waddr = cur_q[BLK_AW-1:0];
        blk_req_o.wdata = '0;
        if (cur_q == {ELEM_AW{1'b1}}) begin
          state_d = ST_IDLE;
        end
        cur_d = cur_q + ELEM_AW'(1);
      end
      ST_IDLE: begin
        if (start) begin
          op_d    = operation_i;
          lidx_d  = first_index_i;
          ridx_d  = last_index_i;
          val_d   = element_value_i;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        acc_d = identity_of(cfg_i.combine_mode);
        if (op_q == OP_WRITE) begin
          if (write_ok) begin
            elem_req_o.we    = 1'b1;
            elem_req_o.waddr = lidx_q;
            elem_req_o.wdata = val_q;
            cur_d            = blk_first;
            stop_d           = blk_stop;
            state_d          = ST_LEFT;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (!query_ok) begin
          res_vld_d = 1'b1;
          res_agg_d = identity_of(cfg_i.combine_mode);
          res_rng_d = 1'b0;
          state_d   = ST_IDLE;
        end else begin
          cur_d   = lidx_q;
          stop_d  = (lb == rb) ? ridx_q : {lb, {OFF_W{1'b1}}};
          state_d = ST_LEFT;
        end
      end
      ST_LEFT: begin
        rd_vld_d = 1'b1;
        rd_blk_d = 1'b0;
        if (cur_q == stop_q) begin
          if (op_q == OP_WRITE || lb == rb) begin
            state_d = ST_DRAIN;
          end else if (rb == lb + BLK_AW'(1)) begin
            cur_d   = {rb, {OFF_W{1'b0}}};
            stop_d  = ridx_q;
            state_d = ST_RIGHT;
          end else begin
            bcur_d  = lb + BLK_AW'(1);
            state_d = ST_MID;
          end
        end else begin
          cur_d = cur_q + ELEM_AW'(1);
        end
      end
      ST_MID: begin
        rd_vld_d = 1'b1;
        rd_blk_d = 1'b1;
        if (bcur_q == rb - BLK_AW'(1)) begin
          cur_d   = {rb, {OFF_W{1'b0}}};
          stop_d  = ridx_q;
          state_d = ST_RIGHT;
        end else begin
          bcur_d = bcur_q + BLK_AW'(1);
        end
      end
      ST_RIGHT: begin
        rd_vld_d = 1'b1;
        rd_blk_d = 1'b0;
        if (cur_q == stop_q) begin
          state_d = ST_DRAIN;
        end else begin
          cur_d = cur_q + ELEM_AW'(1);
        end
      end
      ST_DRAIN: begin
        // The last read lands now; finish the write or hand out the query result.
        if (op_q == OP_WRITE) begin
          blk_req_o.we = 1'b1;
        end else begin
          res_vld_d = 1'b1;
          res_agg_d = acc_next;
          res_rng_d = 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cur_q     <= '0;
      stop_q    <= '0;
      bcur_q    <= '0;
      rd_vld_q  <= 1'b0;
      rd_blk_q  <= 1'b0;
      res_vld_q <= 1'b0;
      op_q      <= OP_WRITE;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      stop_q    <= stop_d;
      bcur_q    <= bcur_d;
      rd_vld_q  <= rd_vld_d;
      rd_blk_q  <= rd_blk_d;
      res_vld_q <= res_vld_d;
      op_q      <= op_d;
    end
  end

  // Item payload and accumulator.
  always_ff @(posedge clk_i) begin
    lidx_q    <= lidx_d;
    ridx_q    <= ridx_d;
    val_q     <= val_d;
    acc_q     <= acc_d;
    res_agg_q <= res_agg_d;
    res_rng_q <= res_rng_d;
  end

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = res_vld_q;
  assign aggregate_o    = res_agg_q;
  assign in_range_o     = res_rng_q;

endmodule

// File: rtl/sqrt_block_range_aggregate_top.sv
// Block-decomposed range aggregate (sum, minimum or maximum) over 1024 signed words.
// Query: setup state, then k reads (k = edge elements plus middle blocks, at most 94)
// made one at a time through the element and block read ports, then drain and the strobe.
// Invalid query: strobe after setup. Write: busy through setup, k <= 32 reads and drain.
// Each result is shown for one cycle and cannot be stalled; the next item is taken then.
// After reset a clearing pass zeroes both memories while busy is high.
module sqrt_block_range_aggregate_top import sbra_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     operation_i,
  input  logic [ELEM_AW-1:0]       first_index_i,
  input  logic [ELEM_AW-1:0]       last_index_i,
  input  logic signed [DATA_W-1:0] element_value_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_AW-1:0]        cfg_addr_i,
  input  logic [CNT_W-1:0]         cfg_wdata_i,
  output logic                     result_valid_o,
  output logic signed [DATA_W-1:0] aggregate_o,
  output logic                     in_range_o
);

  logic [CNT_W-1:0]  element_count_q;
  logic [MODE_W-1:0] combine_mode_q;
  cfg_t              cfg;
  elem_req_t         elem_req;
  blk_req_t          blk_req;
  data_t             elem_rdata, blk_rdata, aggregate;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= '0;
      combine_mode_q  <= MODE_SUM;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_ELEMENT_COUNT: element_count_q <= cfg_wdata_i;
        CFG_COMBINE_MODE:  combine_mode_q  <= cfg_wdata_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.element_count = element_count_q;
  assign cfg.combine_mode  = combine_mode_q;

  // Element store.
  sbra_ram #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (DATA_W)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_req.we),
    .waddr_i (elem_req.waddr),
    .wdata_i (elem_req.wdata),
    .raddr_i (elem_req.raddr),
    .rdata_o (elem_rdata)
  );

  // Per-block aggregate store.
  sbra_ram #(
    .DEPTH (BLK_CNT),
    .WIDTH (DATA_W)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_req.we),
    .waddr_i (blk_req.waddr),
    .wdata_i (blk_req.wdata),
    .raddr_i (blk_req.raddr),
    .rdata_o (blk_rdata)
  );

  // Sequencer and combine datapath.
  sbra_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .first_index_i   (first_index_i),
    .last_index_i    (last_index_i),
    .element_value_i (data_t'(element_value_i)),
    .cfg_i           (cfg),
    .elem_req_o      (elem_req),
    .elem_rdata_i    (elem_rdata),
    .blk_req_o       (blk_req),
    .blk_rdata_i     (blk_rdata),
    .result_valid_o  (result_valid_o),
    .aggregate_o     (aggregate),
    .in_range_o      (in_range_o)
  );

  assign aggregate_o = $signed(aggregate);

`ifndef ASSERT_OFF
  // An accepted item always raises busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result is only shown once the block is free for the next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while the block is still busy");

  // Each item gives at most one result, shown for a single cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // Memory writes never collide with the read of a finished query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !elem_req.we && !blk_req.we)
    else $error("memory write while a result is shown");
`endif

endmodule
